### src/mean_variance_stddev_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mean / variance / standard deviation unit
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MEAN_VARIANCE_STDDEV_UNIT_DEFINES_SVH
`define MEAN_VARIANCE_STDDEV_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define MVS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define MVS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MVS_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define MVS_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

### src/mvs_pkg.sv
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared types and constants of the mean / variance / standard deviation unit.
// ----------------------------------------------------------------------------
package mvs_pkg;

  localparam int MEAN_W   = 24;
  localparam int SSD_W    = 56;
  localparam int VAR_W    = 48;
  localparam int STD_W    = 24;
  localparam int ICNT_W   = 9;
  localparam int STATUS_W = 2;

  // product difference n*sum(x^2) - sum^2 wraps at 64 bits
  localparam int DNUM_W = 64;
  // dividend of the shared divider: a Q.16 scaled difference
  localparam int NUM_W  = DNUM_W + 16;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SINGLE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROP   = 2'd2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQ,
    BK_MUL,
    BK_DMEAN,
    BK_DSSD,
    BK_DVAR,
    BK_SQRT,
    BK_OUT
  } bk_state_t;

endpackage

### src/mvs_channels.sv
// ----------------------------------------------------------------------------
// mvs channels
// Valid/ready channels for samples, configuration and results.
// ----------------------------------------------------------------------------
interface mvs_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;
  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mvs_cfg_if;
  logic valid;
  logic ready;
  logic population_mode;
  modport source (output valid, output population_mode, input ready);
  modport sink   (input valid, input population_mode, output ready);
endinterface

interface mvs_out_if;
  import mvs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [MEAN_W-1:0]   mean_q8;
  logic        [SSD_W-1:0]    sum_sq_dev_q16;
  logic        [VAR_W-1:0]    variance_q16;
  logic        [STD_W-1:0]    std_dev_q8;
  logic        [ICNT_W-1:0]   item_count;
  logic        [STATUS_W-1:0] status;
  modport source (output valid, output mean_q8, output sum_sq_dev_q16, output variance_q16,
                  output std_dev_q8, output item_count, output status, input ready);
  modport sink   (input valid, input mean_q8, input sum_sq_dev_q16, input variance_q16,
                  input std_dev_q8, input item_count, input status, output ready);
endinterface

### src/mvs_ram.sv
// ----------------------------------------------------------------------------
// mvs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### src/mvs_queue.sv
// ----------------------------------------------------------------------------
// mvs_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module mvs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  logic [WIDTH-1:0] entry [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign full     = fill == 2'd2;
  assign empty    = fill == 2'd0;
  assign pop_data = entry[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

### src/mvs_front.sv
// ----------------------------------------------------------------------------
// mvs_front
// Take samples, store them, keep count and sum; close a set into a job.
// ----------------------------------------------------------------------------
`include "mean_variance_stddev_unit_defines.svh"

module mvs_front #(
  parameter int MAX_ITEMS   = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 9,
  parameter int SUM_W       = 24,
  parameter int JOB_W       = 35
) (
  input  logic                             clk,
  input  logic                             rst,
  mvs_in_if.sink                           samples,
  mvs_cfg_if.sink                          cfg,
  output logic                             ram_we,
  output logic [$clog2(MAX_ITEMS)-1:0]     ram_waddr,
  output logic [SAMPLE_BITS-1:0]           ram_wdata,
  output logic                             job_push,
  output logic [JOB_W-1:0]                 job_data,
  input  logic                             job_full,
  input  logic                             store_free
);
  import mvs_pkg::*;

  logic                    population_mode;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] running_sum;
  logic                    overflow_seen;
  logic                    hold;

  logic                    acc;
  logic                    full;
  logic [CNT_W-1:0]        count_next;
  logic signed [SUM_W-1:0] sum_next;
  logic                    ovf_next;

  assign cfg.ready     = 1'b1;
  assign samples.ready = !hold && !job_full;
  assign acc           = samples.valid && samples.ready;
  assign full          = count == CNT_W'(MAX_ITEMS);

  assign ram_we    = acc && !full;
  assign ram_waddr = count[$clog2(MAX_ITEMS)-1:0];
  assign ram_wdata = samples.sample;

  always_comb begin
    count_next = full ? count : count + CNT_W'(1);
    sum_next   = full ? running_sum : running_sum + SUM_W'(samples.sample);
    ovf_next   = overflow_seen || full;
  end

  assign job_push = acc && samples.last;
  assign job_data = {population_mode, ovf_next, sum_next, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      population_mode <= 1'b0;
      count           <= '0;
      running_sum     <= '0;
      overflow_seen   <= 1'b0;
      hold            <= 1'b0;
    end else begin
      if (cfg.valid) begin
        population_mode <= cfg.population_mode;
      end
      if (acc) begin
        if (samples.last) begin
          count         <= '0;
          running_sum   <= '0;
          overflow_seen <= 1'b0;
          hold          <= 1'b1;
        end else begin
          count         <= count_next;
          running_sum   <= sum_next;
          overflow_seen <= ovf_next;
        end
      end else if (store_free) begin
        hold <= 1'b0;
      end
    end
  end

  `MVS_ASSERT_NXT(a_close_holds, clk, rst, acc && samples.last, hold)
  `MVS_ASSERT_IMP(a_hold_blocks, clk, rst, hold, !samples.ready)
  `MVS_ASSERT_IMP(a_write_in_range, clk, rst, ram_we, count < CNT_W'(MAX_ITEMS))
endmodule

### src/mvs_div.sv
// ----------------------------------------------------------------------------
// mvs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvs_div #(
  parameter int NW = 80,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW);

  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  assign quot   = q;
  assign rem_sh = {rem, q[NW-1]};
  assign diff   = rem_sh - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= num;
      rem  <= '0;
      dreg <= den;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DW-1:0];
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

### src/mvs_back.sv
// ----------------------------------------------------------------------------
// mvs_back
// Run one closed set: square pass, products, divisions, root, result word.
// ----------------------------------------------------------------------------
`include "mean_variance_stddev_unit_defines.svh"

module mvs_back #(
  parameter int MAX_ITEMS   = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 9,
  parameter int SUM_W       = 24,
  parameter int JOB_W       = 35
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [JOB_W-1:0]             job_data,
  input  logic                         job_empty,
  output logic                         job_pop,
  output logic                         ram_re,
  output logic [$clog2(MAX_ITEMS)-1:0] ram_raddr,
  input  logic [SAMPLE_BITS-1:0]       ram_rdata,
  output logic                         store_free,
  mvs_out_if.source                    results
);
  import mvs_pkg::*;

  localparam int DEN_W = 2 * CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS;

  bk_state_t state, state_next;

  logic [CNT_W-1:0]         n;
  logic signed [SUM_W-1:0]  s;
  logic                     mode;
  logic                     ovf;
  logic [CNT_W-1:0]         issue_cnt;
  logic                     v1;
  logic                     v2;
  logic signed [SQ_W-1:0]   sq;
  logic [DNUM_W-1:0]        sumsq;
  logic [DNUM_W-1:0]        mul_a;
  logic [SUM_W-1:0]         mul_b;
  logic                     mul_sel;
  logic [DNUM_W-1:0]        prod;
  logic [DNUM_W-1:0]        dnum;
  logic signed [MEAN_W-1:0] mean_r;
  logic [SSD_W-1:0]         ssd_r;
  logic [VAR_W-1:0]         var_r;
  logic [STD_W-1:0]         std_r;
  logic [STATUS_W-1:0]      status_r;
  logic [VAR_W-1:0]         rt_v;
  logic [VAR_W-1:0]         rt_res;
  logic [VAR_W-1:0]         rt_bit;

  logic [SUM_W-1:0]  as;
  logic              var_path;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_busy;
  logic              div_done;
  logic [NUM_W-1:0]  div_q;
  logic [VAR_W:0]    rt_try;
  logic [VAR_W-1:0]  var_sat;

  assign as       = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
  assign var_path = mode || (n >= CNT_W'(2));
  assign rt_try   = {1'b0, rt_res} + {1'b0, rt_bit};
  assign var_sat  = (|div_q[NUM_W-1:VAR_W]) ? '1 : div_q[VAR_W-1:0];

  mvs_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    ram_re     = 1'b0;
    store_free = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    unique case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = BK_SQ;
        end
      end
      BK_SQ: begin
        ram_re = issue_cnt < n;
        if (!ram_re && !v1 && !v2) begin
          store_free = 1'b1;
          state_next = BK_MUL;
        end
      end
      BK_MUL: begin
        if (mul_b == '0 && mul_sel) begin
          div_start  = 1'b1;
          div_num    = NUM_W'(as) << 8;
          div_den    = DEN_W'(n);
          state_next = BK_DMEAN;
        end
      end
      BK_DMEAN: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = NUM_W'(dnum) << 16;
          div_den    = DEN_W'(n);
          state_next = BK_DSSD;
        end
      end
      BK_DSSD: begin
        if (div_done) begin
          if (var_path) begin
            div_start  = 1'b1;
            div_num    = NUM_W'(dnum) << 16;
            div_den    = DEN_W'(n) * DEN_W'(mode ? n : n - CNT_W'(1));
            state_next = BK_DVAR;
          end else begin
            state_next = BK_SQRT;
          end
        end
      end
      BK_DVAR: begin
        if (div_done) begin
          state_next = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (rt_bit == '0) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (results.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign ram_raddr = issue_cnt[$clog2(MAX_ITEMS)-1:0];

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        {mode, ovf, s, n} <= job_data;
        issue_cnt <= '0;
        v1        <= 1'b0;
        v2        <= 1'b0;
        sumsq     <= '0;
      end
      BK_SQ: begin
        v1 <= ram_re;
        v2 <= v1;
        if (ram_re) begin
          issue_cnt <= issue_cnt + CNT_W'(1);
        end
        if (v1) begin
          sq <= $signed(ram_rdata) * $signed(ram_rdata);
        end
        if (v2) begin
          sumsq <= sumsq + DNUM_W'(unsigned'(sq));
        end
        if (store_free) begin
          mul_a   <= sumsq;
          mul_b   <= SUM_W'(n);
          prod    <= '0;
          mul_sel <= 1'b0;
        end
      end
      BK_MUL: begin
        // shift-add, one multiplier bit a cycle
        if (mul_b != '0) begin
          if (mul_b[0]) begin
            prod <= prod + mul_a;
          end
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end else if (!mul_sel) begin
          dnum    <= prod;
          mul_a   <= DNUM_W'(as);
          mul_b   <= as;
          prod    <= '0;
          mul_sel <= 1'b1;
        end else begin
          dnum <= dnum - prod;
        end
      end
      BK_DMEAN: begin
        if (div_done) begin
          if (s[SUM_W-1]) begin
            mean_r <= (div_q > NUM_W'(1 << (MEAN_W - 1)))
                      ? {1'b1, {(MEAN_W-1){1'b0}}} : -div_q[MEAN_W-1:0];
          end else begin
            mean_r <= (div_q > NUM_W'((1 << (MEAN_W - 1)) - 1))
                      ? {1'b0, {(MEAN_W-1){1'b1}}} : div_q[MEAN_W-1:0];
          end
        end
      end
      BK_DSSD: begin
        if (div_done) begin
          ssd_r    <= (|div_q[NUM_W-1:SSD_W]) ? '1 : div_q[SSD_W-1:0];
          status_r <= ovf ? STATUS_DROP : (var_path ? STATUS_OK : STATUS_SINGLE);
          if (!var_path) begin
            var_r  <= '0;
            rt_v   <= '0;
            rt_res <= '0;
            rt_bit <= VAR_W'(1) << (VAR_W - 2);
          end
        end
      end
      BK_DVAR: begin
        if (div_done) begin
          var_r  <= var_sat;
          rt_v   <= var_sat;
          rt_res <= '0;
          rt_bit <= VAR_W'(1) << (VAR_W - 2);
        end
      end
      BK_SQRT: begin
        // digit-by-digit root, two radicand bits a cycle
        if (rt_bit != '0) begin
          if ({1'b0, rt_v} >= rt_try) begin
            rt_v   <= rt_v - rt_try[VAR_W-1:0];
            rt_res <= (rt_res >> 1) + rt_bit;
          end else begin
            rt_res <= rt_res >> 1;
          end
          rt_bit <= rt_bit >> 2;
        end else begin
          std_r <= rt_res[STD_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign results.valid          = state == BK_OUT;
  assign results.mean_q8        = mean_r;
  assign results.sum_sq_dev_q16 = ssd_r;
  assign results.variance_q16   = var_r;
  assign results.std_dev_q8     = std_r;
  assign results.item_count     = ICNT_W'(n);
  assign results.status         = status_r;

  `MVS_ASSERT_IMP(a_div_idle_on_start, clk, rst, div_start, !div_busy)
  `MVS_ASSERT_IMP(a_pass_drained, clk, rst, v2 || v1, state == BK_SQ)
  `MVS_ASSERT_NXT(a_result_held, clk, rst, results.valid && !results.ready, results.valid && $stable(mean_r) && $stable(var_r))
endmodule

### src/mean_variance_stddev_unit.sv
// ----------------------------------------------------------------------------
// mean_variance_stddev_unit
// Mean, sum of squared deviations, variance and standard deviation of a set.
// ----------------------------------------------------------------------------
// Samples load one word per cycle into a sample RAM, unless the front end stalls,
// while a count and a running sum are kept. The word marked last closes the set.
// The front end then stalls until the back end has popped the job and read the
// set out of the RAM. The front end then takes the next set while the back end
// finishes. The back end works through the closing set with a square pass (one
// RAM read a cycle), shift-add products n*sum(x^2) and sum^2, two or three
// divisions on the shared restoring divider (the variance division is skipped
// for a single-sample set in sample mode) and the root.
// Samples past MAX_ITEMS are dropped and reported in the status field.
// A single-sample set in sample mode reports zero variance and status 1.
// ----------------------------------------------------------------------------
module mean_variance_stddev_unit #(
  parameter int MAX_ITEMS   = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mvs_in_if.sink     samples,
  mvs_cfg_if.sink    cfg,
  mvs_out_if.source  results
);
  import mvs_pkg::*;

  // count holds 0..MAX_ITEMS, sum holds MAX_ITEMS full-scale samples
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W = SAMPLE_BITS + AW;
  // job word: mode, overflow flag, sum, count
  localparam int JOB_W = 2 + SUM_W + CNT_W;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic                   job_push;
  logic [JOB_W-1:0]       job_in;
  logic                   job_full;
  logic                   job_pop;
  logic [JOB_W-1:0]       job_out;
  logic                   job_empty;
  logic                   store_free;

  // front: accept words, write the store, close sets into jobs
  mvs_front #(
    .MAX_ITEMS   (MAX_ITEMS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .cfg        (cfg),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .job_push   (job_push),
    .job_data   (job_in),
    .job_full   (job_full),
    .store_free (store_free)
  );

  // sample store, written by the front, read back by the square pass
  mvs_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // hand closed sets across so either side may stall alone
  mvs_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  // back: arithmetic and the registered result word
  mvs_back #(
    .MAX_ITEMS   (MAX_ITEMS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_data   (job_out),
    .job_empty  (job_empty),
    .job_pop    (job_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .store_free (store_free),
    .results    (results)
  );
endmodule
